[rtl/core/indexed_sequence_store_macros.svh]
// Assertion macros shared by the indexed sequence store RTL.
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/isq_pkg.sv]
// Shared constants, codes and types of the indexed sequence store.
`default_nettype none

package isq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = 5;
    localparam int POS_W      = 5;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    localparam int IN_BITS     = POS_W + DATA_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = DATA_WIDTH + CNT_W + 1 + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_READ       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_WR,
        ST_TK_RD,
        ST_TK_CAP,
        ST_MV_RD,
        ST_MV_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/isq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/indexed_sequence_store.sv]
// Top level of the indexed sequence store: request sequencer over a slot RAM.
//
//  Channel | Dir | Fields (low bit up)
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tuser: operation; tdata: position, data_in
//  m_*     | out | tdata: data_out, count, is_empty, status
//
// From one accepted beat to the next, a failed request or a clear goes straight
// to the done state, a read fetches one slot, and an add or a take moves m slots:
// each move is one RAM read then one write through the single read/write port pair,
// stepped by one shared index adder.
// Insert/push moves used-pos slots, remove/pop moves used-pos-1 slots.
// Reset clears the count and the sequencer; slot contents are not cleared.
// A finished result waits in the output register while the next beat enters;
// the sequencer stalls only when it has a new result and the register is full and not draining.
`default_nettype none
`include "indexed_sequence_store_macros.svh"

module indexed_sequence_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [isq_pkg::IN_TDATA_W-1:0]  s_tdata,  // position, data_in
    input  logic [isq_pkg::OP_W-1:0]        s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [isq_pkg::OUT_TDATA_W-1:0] m_tdata   // data_out, count, is_empty, status
);

    import isq_pkg::*;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    status_t               status_reg, status_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_empty_reg, out_empty_next;
    status_t               out_status_reg, out_status_next;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  step_down;
    logic [CNT_W-1:0]      step_val;
    op_t                   in_op;
    logic [POS_W-1:0]      in_pos;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  out_load;

    // Slot storage
    isq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Unpack the input beat
    assign in_op   = op_t'(s_tuser);
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_word = s_tdata[POS_W +: DATA_WIDTH];

    // Shared index stepper: down while opening a gap, up while closing one
    assign step_down = (state_reg == ST_SH_RD) || (state_reg == ST_SH_WR);
    assign step_val  = step_down ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer: next state, RAM controls and working registers
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        word_next   = word_reg;
        result_next = result_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[ADDR_W-1:0];
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = step_val[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    word_next   = in_word;
                    result_next = '0;
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                    case (in_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
                        begin
                            if (used_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if ((in_op == OP_INSERT) && (in_pos > used_reg))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                if (in_op == OP_PUSH_FRONT)
                                    pos_next = '0;
                                else if (in_op == OP_PUSH_BACK)
                                    pos_next = used_reg;
                                else
                                    pos_next = in_pos;
                                idx_next   = used_reg;
                                state_next = ST_SH_RD;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE:
                        begin
                            if (used_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if ((in_op == OP_REMOVE) && (in_pos >= used_reg))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                if (in_op == OP_POP_FRONT)
                                    pos_next = '0;
                                else if (in_op == OP_POP_BACK)
                                    pos_next = used_reg - CNT_W'(1);
                                else
                                    pos_next = in_pos;
                                state_next = ST_TK_RD;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_pos >= used_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                pos_next   = in_pos;
                                state_next = ST_TK_RD;
                            end
                        end
                        default:
                        begin
                            used_next = '0;
                        end
                    endcase
                end
            end

            // Open the gap one slot at a time, then drop the word in
            ST_SH_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SH_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[ADDR_W-1:0];
                    wr_data    = word_reg;
                    used_next  = used_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_SH_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = step_val;
                state_next = ST_SH_RD;
            end

            // Fetch the word at the target position
            ST_TK_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg[ADDR_W-1:0];
                idx_next   = pos_reg;
                state_next = ST_TK_CAP;
            end

            ST_TK_CAP:
            begin
                result_next = rd_data;
                state_next  = (op_reg == OP_READ) ? ST_DONE : ST_MV_RD;
            end

            // Close the gap one slot at a time
            ST_MV_RD:
            begin
                if (step_val < used_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_MV_WR;
                end
                else
                begin
                    used_next  = used_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_MV_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = step_val;
                state_next = ST_MV_RD;
            end

            // Hold until the output register is free
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register load and drain
    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            m_tvalid_next   = 1'b1;
            out_data_next   = result_reg;
            out_count_next  = used_reg;
            out_empty_next  = (used_reg == '0);
            out_status_next = status_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        result_reg     <= result_next;
        status_reg     <= status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    // Pack the output beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_status_reg, out_empty_reg, out_count_reg, out_data_reg});

    // Checks
    `ISQ_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ISQ_ASSERT_NOW(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= used_reg, "slot write past the end")
    `ISQ_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted beat not taken up")
    `ISQ_ASSERT_NOW(a_fail_zero_data, m_tvalid && (out_status_reg != STAT_OK), out_data_reg == '0, "failed request returned data")
    `ISQ_ASSERT_NOW(a_empty_matches, m_tvalid, out_empty_reg == (out_count_reg == '0), "empty flag disagrees with count")

endmodule

`default_nettype wire

[bench/isq_checker.sv]
// Checker for the indexed sequence store: tracks request beats, predicts and compares result beats.
module isq_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [isq_pkg::IN_TDATA_W-1:0]  s_tdata,  // position, data_in
    input  logic [isq_pkg::OP_W-1:0]        s_tuser,  // operation
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [isq_pkg::OUT_TDATA_W-1:0] m_tdata,  // data_out, count, is_empty, status
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_checked,
    output int                              full_seen,
    output int                              empty_seen,
    output int                              range_seen
);
    import isq_pkg::*;

    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] word;
        logic [CNT_W-1:0]      count;
        logic                  empty;
        status_t               status;
    } outcome_t;

    // Predicted contents of the store
    logic [DATA_WIDTH-1:0] held_words [CAPACITY];
    int                    held_count;

    outcome_t expected_results [$];
    int       errs;
    int       n_checked;
    int       n_full;
    int       n_empty;
    int       n_range;

    task automatic report_error(input string msg);
        if (errs < MAX_PRINTED)
        begin
            $display("isq_checker: %s", msg);
        end
        errs++;
    endtask

    // Apply one request to the predicted store and return the result it yields
    function automatic outcome_t apply_request(input op_t op, input int pos,
                                               input logic [DATA_WIDTH-1:0] word);
        outcome_t r;
        int       at;
        int       i;
        r        = '0;
        r.op     = op;
        r.status = STAT_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (held_count >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    at = (op == OP_PUSH_FRONT) ? 0 : (op == OP_PUSH_BACK) ? held_count : pos;
                    if (at > held_count)
                    begin
                        r.status = STAT_RANGE;
                    end
                    else
                    begin
                        for (i = held_count; i > at; i--)
                            held_words[i] = held_words[i-1];
                        held_words[at] = word;
                        held_count++;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE:
            begin
                if (held_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    at = (op == OP_POP_FRONT) ? 0 : (op == OP_POP_BACK) ? held_count - 1 : pos;
                    if (at >= held_count)
                    begin
                        r.status = STAT_RANGE;
                    end
                    else
                    begin
                        r.word = held_words[at];
                        for (i = at; i + 1 < held_count; i++)
                            held_words[i] = held_words[i+1];
                        held_count--;
                    end
                end
            end
            OP_READ:
            begin
                if (pos >= held_count)
                    r.status = STAT_RANGE;
                else
                    r.word = held_words[pos];
            end
            default:
            begin
                held_count = 0;
            end
        endcase
        r.count = held_count[CNT_W-1:0];
        r.empty = (held_count == 0);
        return r;
    endfunction

    // Compare result beats against predictions, then queue the prediction for a new request beat
    always @(posedge clk or negedge rst_n)
    begin : track_beats
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            held_count = 0;
            expected_results.delete();
            errs       = 0;
            n_checked  = 0;
            n_full     = 0;
            n_empty    = 0;
            n_range    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got        = '0;
                got.word   = m_tdata[DATA_WIDTH-1:0];
                got.count  = m_tdata[DATA_WIDTH +: CNT_W];
                got.empty  = m_tdata[DATA_WIDTH + CNT_W];
                got.status = status_t'(m_tdata[DATA_WIDTH + CNT_W + 1 +: STAT_W]);
                if (expected_results.size() == 0)
                begin
                    report_error($sformatf("result beat with nothing expected: tdata 0x%0h",
                                           m_tdata));
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.word !== want.word)
                        report_error($sformatf("result %0d (%s): data_out 0x%0h, expected 0x%0h",
                                               n_checked, want.op.name(), got.word, want.word));
                    if (got.count !== want.count)
                        report_error($sformatf("result %0d (%s): count %0d, expected %0d",
                                               n_checked, want.op.name(), got.count, want.count));
                    if (got.empty !== want.empty)
                        report_error($sformatf("result %0d (%s): is_empty %0b, expected %0b",
                                               n_checked, want.op.name(), got.empty, want.empty));
                    if (got.status !== want.status)
                        report_error($sformatf("result %0d (%s): status %0d, expected %s",
                                               n_checked, want.op.name(), got.status,
                                               want.status.name()));
                    case (want.status)
                        STAT_FULL:  n_full++;
                        STAT_EMPTY: n_empty++;
                        STAT_RANGE: n_range++;
                        default:    ;
                    endcase
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        apply_request(op_t'(s_tuser),
                                                      int'(s_tdata[POS_W-1:0]),
                                                      s_tdata[POS_W +: DATA_WIDTH]));
            end
        end
        fail_count      <= errs;
        outstanding     <= expected_results.size();
        results_checked <= n_checked;
        full_seen       <= n_full;
        empty_seen      <= n_empty;
        range_seen      <= n_range;
    end

endmodule

[bench/tb_top.sv]
// Testbench top for the indexed sequence store: clock, reset, request stimulus and verdict.
module tb_top;
    import isq_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 80;
    localparam int TOTAL_ITEMS  = 1450;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int results_checked;
    int full_seen;
    int empty_seen;
    int range_seen;

    // Stimulus bookkeeping
    int sent_count   = 0;
    int burst_left   = 0;
    int level        = 0;
    int quiet_cycles = 0;
    int fill_runs    = 0;
    int drain_runs   = 0;
    bit eager        = 1'b0;
    bit hold_request = 1'b0;
    int rx_mode      = 0;

    indexed_sequence_store DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    isq_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .empty_seen      (empty_seen),
        .range_seen      (range_seen)
    );

    always #1 clk = ~clk;

    // Hold reset from time zero, then release it
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // End the run when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive m_tready: long hold-off on request, otherwise always-ready, random or run pattern
    initial
    begin : rx_driver
        int run_left;
        bit ready_phase;
        run_left    = 0;
        ready_phase = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            ready_phase = ~ready_phase;
                            run_left    = ready_phase ? $urandom_range(1, 12)
                                                      : $urandom_range(1, 8);
                        end
                        run_left--;
                        m_tready <= ready_phase;
                    end
                endcase
            end
        end
    end

    // Keep a rough occupancy count so sequences can aim at full and empty
    function automatic void track_level(input op_t op, input int pos);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (level < CAPACITY) level++;
            OP_INSERT:                   if (level < CAPACITY && pos <= level) level++;
            OP_POP_FRONT, OP_POP_BACK:   if (level > 0) level--;
            OP_REMOVE:                   if (level > 0 && pos < level) level--;
            OP_CLEAR:                    level = 0;
            default:                     ;
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request beat, with burst gaps, and hold it until accepted
    task automatic send_request(input op_t op, input int pos, input logic [DATA_WIDTH-1:0] word);
        logic [IN_TDATA_W-1:0] beat;
        int                    gap;
        beat                      = '0;
        beat[POS_W-1:0]           = pos[POS_W-1:0];
        beat[POS_W +: DATA_WIDTH] = word;
        if (burst_left == 0)
        begin
            gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_level(op, pos);
        sent_count++;
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_wait();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // One random sequence: fill to full, drain to empty, valid mix, or noise
    task automatic run_sequence();
        int kind;
        int n;
        int k;
        op_t op;
        kind = $urandom_range(0, 9);
        if (kind <= 2)
        begin
            fill_runs++;
            while (level < CAPACITY)
            begin
                case ($urandom_range(0, 4))
                    0:       send_request(OP_PUSH_FRONT, $urandom_range(0, 16), pick_word());
                    1:       send_request(OP_PUSH_BACK, $urandom_range(0, 16), pick_word());
                    2:       send_request(OP_READ, (level > 0) ? $urandom_range(0, level - 1) : 0,
                                          pick_word());
                    default: send_request(OP_INSERT, $urandom_range(0, level), pick_word());
                endcase
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
            begin
                op = op_t'($urandom_range(0, 2));
                send_request(op, $urandom_range(0, 16), pick_word());
            end
        end
        else if (kind <= 5)
        begin
            drain_runs++;
            while (level > 0)
            begin
                case ($urandom_range(0, 4))
                    0:       send_request(OP_POP_FRONT, $urandom_range(0, 16), pick_word());
                    1:       send_request(OP_POP_BACK, $urandom_range(0, 16), pick_word());
                    2:       send_request(OP_READ, $urandom_range(0, level - 1), pick_word());
                    default: send_request(OP_REMOVE, $urandom_range(0, level - 1), pick_word());
                endcase
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
            begin
                op = op_t'($urandom_range(3, 6));
                send_request(op, $urandom_range(0, 16), pick_word());
            end
        end
        else if (kind <= 8)
        begin
            for (k = 0; k < 24; k++)
            begin
                op = op_t'($urandom_range(0, 6));
                if ($urandom_range(0, 4) == 0)
                    send_request(op, $urandom_range(0, 16), pick_word());
                else if (op == OP_INSERT)
                    send_request(op, $urandom_range(0, level), pick_word());
                else
                    send_request(op, (level > 0) ? $urandom_range(0, level - 1) : 0,
                                 pick_word());
            end
        end
        else
        begin
            for (k = 0; k < 10; k++)
            begin
                op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : op_t'($urandom_range(0, 6));
                send_request(op, $urandom_range(0, 16), pick_word());
            end
        end
    endtask

    initial
    begin : stimulus
        int seq_count;
        seq_count = 0;
        rx_mode   = 1;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: empty-store takes and reads, edges of insert and remove, clear
        send_request(OP_READ,       0,  32'h0);
        send_request(OP_POP_FRONT,  0,  32'h0);
        send_request(OP_POP_BACK,   0,  32'h0);
        send_request(OP_REMOVE,     16, 32'h0);
        send_request(OP_INSERT,     0,  32'h8000_0001);
        send_request(OP_REMOVE,     0,  32'h0);
        send_request(OP_PUSH_BACK,  0,  32'hFFFF_FFFF);
        send_request(OP_PUSH_FRONT, 31, 32'h0000_0000);
        send_request(OP_INSERT,     1,  32'hA5A5_A5A5);
        send_request(OP_INSERT,     4,  32'h1234_5678);
        send_request(OP_INSERT,     3,  32'h5A5A_5A5A);
        send_request(OP_READ,       3,  32'h0);
        send_request(OP_READ,       16, 32'h0);
        send_request(OP_READ,       0,  32'h0);
        send_request(OP_REMOVE,     1,  32'h0);
        send_request(OP_REMOVE,     3,  32'h0);
        send_request(OP_POP_FRONT,  0,  32'h0);
        send_request(OP_POP_BACK,   0,  32'h0);
        send_request(OP_READ,       0,  32'h0);
        send_request(OP_CLEAR,      0,  32'hFFFF_FFFF);
        send_request(OP_PUSH_BACK,  0,  32'hDEAD_BEEF);
        send_request(OP_CLEAR,      0,  32'h0);
        send_request(OP_CLEAR,      0,  32'h0);
        send_request(OP_POP_BACK,   0,  32'h0);
        drain_wait();

        // Hold the receiver off while requests keep coming, so the block backs up
        eager        = 1'b1;
        rx_mode      = 0;
        hold_request = 1'b1;
        repeat (30) send_request(op_t'($urandom_range(0, 6)), $urandom_range(0, 16), pick_word());
        drain_wait();

        // Random sequences under changing flow-control patterns
        while (sent_count < TOTAL_ITEMS)
        begin
            eager   = ($urandom_range(0, 3) == 0);
            rx_mode = $urandom_range(0, 2);
            run_sequence();
            seq_count++;
            if (seq_count % 15 == 0)
                drain_wait();
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d results checked, %0d fill and %0d drain sequences",
                 sent_count, results_checked, fill_runs, drain_runs);
        $display("summary: statuses seen - full %0d, empty %0d, out of range %0d",
                 full_seen, empty_seen, range_seen);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
